// ===== sv/cblm_pkg.sv =====
package cblm_pkg;

  localparam int RateW    = 20;
  localparam int BitsW    = 20;
  localparam int LoadW    = 7;
  localparam int LenW     = 4;
  localparam int QuarterW = RateW - 2;
  localparam int DivSteps = 7;
  localparam int NumW     = BitsW + DivSteps;
  localparam int DenW     = QuarterW + DivSteps - 1;
  localparam int StepW    = 3;
  localparam int AddW     = 8;
  localparam int SumW     = LoadW + 2;

  localparam logic [RateW-1:0]   RateReset = 20'd500000;
  localparam logic [BitsW-1:0]   BitsMax   = 20'hFFFFF;
  localparam logic [AddW-1:0]    FrameBase = 8'd41;
  localparam logic [AddW-1:0]    ExtBits   = 8'd18;
  localparam logic [LenW-1:0]    MaxBytes  = 4'd8;
  localparam logic [LoadW-1:0]   FullLoad  = 7'd100;
  localparam logic [LoadW-1:0]   MinLoad   = 7'd1;
  localparam logic [StepW-1:0]   LastStep  = 3'd6;

  localparam logic ModeFrame = 1'b0;
  localparam logic ModeTick  = 1'b1;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } state_e;

endpackage

// ===== sv/cblm_in_if.sv =====
interface cblm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [cblm_pkg::LenW-1:0]   data_length;
  logic                        extended_id;

  modport source (output valid, output mode, output data_length, output extended_id,
                  input ready);
  modport sink   (input valid, input mode, input data_length, input extended_id,
                  output ready);
endinterface

// ===== sv/cblm_out_if.sv =====
interface cblm_out_if;
  logic                        valid;
  logic                        ready;
  logic [cblm_pkg::LoadW-1:0]  load_percent;

  modport source (output valid, output load_percent, input ready);
  modport sink   (input valid, input load_percent, output ready);
endinterface

// ===== sv/can_bus_load_meter_unit.sv =====
// CAN bus load meter. A frame beat (mode 0) adds 41 + 9 per data byte (at most 8) + 18 for an
// extended identifier to a saturating 20-bit bit count; its result is loaded into the output
// register at the accepting edge. A tick beat (mode 1) closes a quarter second: the sample
// min(100, bits*100/(bit_rate/4)) comes from a restoring divider that retires one quotient bit
// per cycle, then the smoothed load becomes (old*3 + sample)/4 (at least 1 if any bits were
// counted) and the count clears. A tick runs setup, 7 divider steps and an update that waits
// for a free output register. Every beat returns one load_percent beat; a result waiting in
// the output register holds off the next beat until it is taken. bit_rate is written through
// cfg_we_i/cfg_wdata_i; the user must do so only while idle, as the block does not enforce it.
module can_bus_load_meter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cblm_pkg::RateW-1:0]  cfg_wdata_i,
  cblm_in_if.sink                     in_i,
  cblm_out_if.source                  out_o
);
  import cblm_pkg::*;

  state_e                state_q, state_d;
  logic [RateW-1:0]      rate_q;
  logic [BitsW-1:0]      bits_q, bits_d;
  logic [LoadW-1:0]      smooth_q, smooth_d;
  logic [LoadW-1:0]      out_load_q, out_load_d;
  logic                  out_valid_q, out_valid_d;
  logic [NumW-1:0]       num_q, num_d;
  logic [DenW-1:0]       den_q, den_d;
  logic [DivSteps-1:0]   quot_q, quot_d;
  logic [StepW-1:0]      step_q, step_d;
  logic                  sat_q, sat_d;

  logic                  out_free;
  logic                  accept;
  logic [QuarterW-1:0]   quarter;
  logic [LenW-1:0]       len_c;
  logic [AddW-1:0]       add_bits;
  logic [BitsW:0]        bits_sum;
  logic                  ge;
  logic [LoadW-1:0]      sample;
  logic [SumW-1:0]       mix;
  logic [LoadW-1:0]      next_load;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == StIdle) && out_free;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.load_percent = out_load_q;

  assign quarter  = rate_q[RateW-1:2];
  assign len_c    = (in_i.data_length > MaxBytes) ? MaxBytes : in_i.data_length;
  assign add_bits = FrameBase + {1'b0, len_c, 3'b000} + {4'b0000, len_c}
                  + (in_i.extended_id ? ExtBits : '0);
  assign bits_sum = {1'b0, bits_q} + {{(BitsW + 1 - AddW){1'b0}}, add_bits};

  assign ge        = num_q >= {{(NumW - DenW){1'b0}}, den_q};
  assign sample    = sat_q ? FullLoad : quot_q;
  assign mix       = {1'b0, smooth_q, 1'b0} + {2'b00, smooth_q} + {2'b00, sample};
  assign next_load = ((mix[SumW-1:2] == '0) && (bits_q != '0)) ? MinLoad : mix[SumW-1:2];

  always_comb begin
    state_d     = state_q;
    bits_d      = bits_q;
    smooth_d    = smooth_q;
    out_load_d  = out_load_q;
    out_valid_d = out_valid_q && !out_o.ready;
    num_d       = num_q;
    den_d       = den_q;
    quot_d      = quot_q;
    step_d      = step_q;
    sat_d       = sat_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_i.mode == ModeFrame) begin
            bits_d      = bits_sum[BitsW] ? BitsMax : bits_sum[BitsW-1:0];
            out_load_d  = smooth_q;
            out_valid_d = 1'b1;
          end else begin
            num_d   = {1'b0, bits_q, 6'b0} + {2'b00, bits_q, 5'b0} + {5'b0, bits_q, 2'b0};
            den_d   = {quarter, {(DivSteps - 1){1'b0}}};
            sat_d   = bits_q >= {{(BitsW - QuarterW){1'b0}}, quarter};
            quot_d  = '0;
            step_d  = LastStep;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        if (ge) begin
          num_d = num_q - {{(NumW - DenW){1'b0}}, den_q};
        end
        quot_d = {quot_q[DivSteps-2:0], ge};
        den_d  = {1'b0, den_q[DenW-1:1]};
        step_d = step_q - 3'd1;
        if (step_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          smooth_d    = next_load;
          out_load_d  = next_load;
          out_valid_d = 1'b1;
          bits_d      = '0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rate_q      <= RateReset;
      bits_q      <= '0;
      smooth_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bits_q      <= bits_d;
      smooth_q    <= smooth_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_load_q <= out_load_d;
    num_q      <= num_d;
    den_q      <= den_d;
    quot_q     <= quot_d;
    step_q     <= step_d;
    sat_q      <= sat_d;
  end

endmodule

// ===== sv/cblm_checker.sv =====
module cblm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_mode_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [cblm_pkg::LoadW-1:0]  out_load_i
);
  import cblm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_load_i))
    else $error("stalled result changed");

  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_load_i <= FullLoad)
    else $error("load above full scale");

  a_frame_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == ModeFrame) |=> out_valid_i)
    else $error("frame beat gave no result");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == ModeTick) |=> !in_ready_i)
    else $error("beat taken while divider busy");

endmodule

bind can_bus_load_meter_unit cblm_checker u_cblm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_load_i  (out_o.load_percent)
);

// ===== dv/can_bus_load_meter_unit_tb.sv =====
module can_bus_load_meter_unit_tb;
  import cblm_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int SettleTicks = 16;

  class load_scoreboard;
    logic [RateW-1:0] bit_rate;
    logic [BitsW-1:0] bits_in_window;
    logic [LoadW-1:0] smoothed;
    logic [LoadW-1:0] loads_due[$];
    int               errors;

    function new();
      bit_rate       = RateReset;
      bits_in_window = '0;
      smoothed       = '0;
      errors         = 0;
    endfunction

    function void note_beat(logic mode, logic [LenW-1:0] len, logic ext);
      logic [LenW-1:0]    bytes;
      logic [31:0]        add;
      logic [31:0]        sum;
      logic [QuarterW-1:0] quarter;
      logic [63:0]        sample;
      logic [63:0]        next_load;
      if (mode == ModeFrame) begin
        bytes = (len > MaxBytes) ? MaxBytes : len;
        add   = 32'(FrameBase) + 32'(bytes) * 32'd9 + (ext ? 32'(ExtBits) : 32'd0);
        sum   = 32'(bits_in_window) + add;
        bits_in_window = (sum > 32'(BitsMax)) ? BitsMax : sum[BitsW-1:0];
      end else begin
        quarter = bit_rate[RateW-1:2];
        if (quarter == '0) begin
          sample = 64'd100;
        end else begin
          sample = (64'(bits_in_window) * 64'd1000 / 64'(quarter)) / 64'd10;
          if (sample > 64'd100) sample = 64'd100;
        end
        next_load = (64'(smoothed) * 64'd3 + sample) / 64'd4;
        if (next_load == 64'd0 && bits_in_window != '0) next_load = 64'd1;
        smoothed       = next_load[LoadW-1:0];
        bits_in_window = '0;
      end
      loads_due.push_back(smoothed);
    endfunction

    function void check_beat(logic [LoadW-1:0] got);
      logic [LoadW-1:0] want;
      if (loads_due.size() == 0) begin
        $display("%0t: unexpected load_percent beat, expected none, got %0d", $time, got);
        errors++;
      end else begin
        want = loads_due.pop_front();
        if (got !== want) begin
          $display("%0t: load_percent mismatch, expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [RateW-1:0] cfg_wdata_i;
  int               cycle_count;
  bit               src_gaps_on;
  bit               sink_stall_on;
  load_scoreboard   load_sb;

  cblm_in_if  in_if ();
  cblm_out_if out_if ();

  can_bus_load_meter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // note the input beat before checking; a frame's result is registered and answers in the cycle after
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        load_sb.note_beat(in_if.mode, in_if.data_length, in_if.extended_id);
      if (out_if.valid && out_if.ready)
        load_sb.check_beat(out_if.load_percent);
    end
  end

  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (sink_stall_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = $urandom_range(0, 20);
      end
    end
  end

  task automatic send_beat(logic mode, logic [LenW-1:0] len, logic ext);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= mode;
    in_if.data_length <= len;
    in_if.extended_id <= ext;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // hold off until every load has come back, then let the block go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (load_sb.loads_due.size() != 0);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_bit_rate(logic [RateW-1:0] rate);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rate;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    load_sb.bit_rate = rate;
  endtask

  task automatic send_frame(logic [LenW-1:0] len, logic ext);
    send_beat(ModeFrame, len, ext);
  endtask

  task automatic send_tick();
    send_beat(ModeTick, LenW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int               n_items;
    int               tick_every;
    logic [LenW-1:0]  len;
    logic [RateW-1:0] rate;
    load_sb            = new();
    src_gaps_on        = 1'b1;
    sink_stall_on      = 1'b1;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.mode         = ModeFrame;
    in_if.data_length  = '0;
    in_if.extended_id  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick();
    send_frame(4'd0, 1'b0);
    send_frame(4'd8, 1'b1);
    send_frame(4'd15, 1'b0);
    send_frame(4'd9, 1'b1);
    send_tick();
    send_tick();
    write_bit_rate(20'd0);
    send_frame(4'd3, 1'b0);
    send_tick();
    send_tick();
    write_bit_rate(20'd3);
    send_tick();
    write_bit_rate(20'd4);
    send_frame(4'd5, 1'b1);
    send_tick();
    write_bit_rate(20'hFFFFF);
    send_frame(4'd7, 1'b1);
    send_tick();
    write_bit_rate(20'd1000000);
    send_frame(4'd0, 1'b0);
    send_tick();
    write_bit_rate(20'd1000);
    send_frame(4'd1, 1'b0);
    send_frame(4'd2, 1'b1);
    send_frame(4'd4, 1'b0);
    send_tick();
    send_tick();

    // run a burst of frames back to back
    write_bit_rate(20'd1000000);
    src_gaps_on   = 1'b0;
    sink_stall_on = 1'b0;
    repeat (24) send_frame(4'd8, 1'b1);
    send_frame(4'd2, 1'b0);
    send_tick();
    send_tick();

    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 7))
        0:       rate = 20'd4;
        1:       rate = 20'hFFFFF;
        2:       rate = 20'd1000000;
        3:       rate = RateW'($urandom_range(0, 3));
        default: rate = RateW'($urandom_range(400, 40000));
      endcase
      write_bit_rate(rate);
      src_gaps_on   = (phase < 6) && (phase % 3 != 1);
      sink_stall_on = (phase < 6) && (phase % 3 != 2);
      n_items    = $urandom_range(90, 130);
      tick_every = $urandom_range(3, 40);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(1, tick_every) == 1) begin
          send_tick();
        end else begin
          if ($urandom_range(0, 7) == 0) len = LenW'($urandom_range(9, 15));
          else                           len = LenW'($urandom_range(0, 8));
          send_frame(len, 1'($urandom_range(0, 1)));
        end
      end
    end

    settle();
    if (load_sb.errors == 0 && load_sb.loads_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
